@@ hw/rtl/bsf_pkg.sv @@
`timescale 1ns / 1ps
package bsf_pkg;
   localparam int VERTEX_MAX_DEF   = 64;
   localparam int EDGE_MAX_DEF     = 1024;
   localparam int WEIGHT_BITS_DEF  = 32;
   localparam int END_BITS         = 6;
   localparam int WEIGHT_PORT_BITS = 32;
   localparam int VCOUNT_BITS      = 7;
   localparam int CSR_ADDR_BITS    = 3;
   localparam int CSR_DATA_BITS    = 32;
endpackage

@@ hw/rtl/bsf_ram.sv @@
`timescale 1ns / 1ps
module bsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hw/rtl/boruvka_spanning_forest.sv @@
`timescale 1ns / 1ps
// Boruvka spanning forest. Edges are loaded one per cycle while busy is low;
// the request with last_edge set starts the run and busy stays high until the
// last result has been strobed. A run goes in rounds; each round scans every
// stored edge (an edge with an out-of-range endpoint is skipped, one inside a
// component is not a candidate), walks the union-find trees and then makes a
// merge pass over the components. The tree edges are output at the end.
// Results come out on rsp_valid for one cycle each and cannot be held off by
// the receiver.
module boruvka_spanning_forest #(
   parameter int MAX_VERTICES = bsf_pkg::VERTEX_MAX_DEF,
   parameter int MAX_EDGES    = bsf_pkg::EDGE_MAX_DEF,
   parameter int WEIGHT_BITS  = bsf_pkg::WEIGHT_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic [bsf_pkg::END_BITS-1:0]                req_edge_from,
   input  logic [bsf_pkg::END_BITS-1:0]                req_edge_to,
   input  logic signed [bsf_pkg::WEIGHT_PORT_BITS-1:0] req_edge_weight,
   input  logic                                        req_last_edge,
   output logic                                        rsp_valid,
   output logic [bsf_pkg::END_BITS-1:0]                rsp_tree_from,
   output logic [bsf_pkg::END_BITS-1:0]                rsp_tree_to,
   output logic signed [bsf_pkg::WEIGHT_PORT_BITS-1:0] rsp_tree_weight,
   output logic                                        rsp_has_edge,
   output logic                                        rsp_last_result,
   output logic                                        rsp_edges_dropped,
   input  logic                                        psel,
   input  logic                                        penable,
   input  logic                                        pwrite,
   input  logic [bsf_pkg::CSR_ADDR_BITS-1:0]           paddr,
   input  logic [bsf_pkg::CSR_DATA_BITS-1:0]           pwdata,
   output logic [bsf_pkg::CSR_DATA_BITS-1:0]           prdata,
   output logic                                        pready
);
   localparam int EB   = bsf_pkg::END_BITS;
   localparam int SW   = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
   localparam int VB   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VCW  = $clog2(MAX_VERTICES + 1);
   localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW  = $clog2(MAX_EDGES + 1);
   localparam int RKW  = $clog2(VB + 1);
   localparam int EDW  = 2 * EB + SW;
   localparam int CHW  = EAW + SW;
   localparam int VCB  = bsf_pkg::VCOUNT_BITS;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RUN   = 5'd1;
   localparam logic [4:0] S_INIT  = 5'd2;
   localparam logic [4:0] S_RND   = 5'd3;
   localparam logic [4:0] S_ERD   = 5'd4;
   localparam logic [4:0] S_EDAT  = 5'd5;
   localparam logic [4:0] S_FRD   = 5'd6;
   localparam logic [4:0] S_FP    = 5'd7;
   localparam logic [4:0] S_FGP   = 5'd8;
   localparam logic [4:0] S_FDONE = 5'd9;
   localparam logic [4:0] S_CRD   = 5'd10;
   localparam logic [4:0] S_CCK   = 5'd11;
   localparam logic [4:0] S_NEXTE = 5'd12;
   localparam logic [4:0] S_MSEL  = 5'd13;
   localparam logic [4:0] S_MCH   = 5'd14;
   localparam logic [4:0] S_MED   = 5'd15;
   localparam logic [4:0] S_RKA   = 5'd16;
   localparam logic [4:0] S_RKB   = 5'd17;
   localparam logic [4:0] S_OUT   = 5'd18;
   localparam logic [4:0] S_ORD   = 5'd19;
   localparam logic [4:0] S_OCH   = 5'd20;
   localparam logic [4:0] S_OED   = 5'd21;
   localparam logic [4:0] S_EMPTY = 5'd22;

   logic [4:0]            st_ff, st_in;
   logic [VCB-1:0]        vc_ff, vc_in;
   logic [ECW-1:0]        total_ff, total_in;
   logic [ECW-1:0]        e_ff, e_in;
   logic                  ovf_ff, ovf_in;
   logic [VCW-1:0]        i_ff, i_in;
   logic [VCW-1:0]        cnt_ff, cnt_in;
   logic [VCW-1:0]        comp_ff, comp_in;
   logic [VCW-1:0]        k_ff, k_in;
   logic                  any_ff, any_in;
   logic                  mode_ff, mode_in;
   logic                  fsel_ff, fsel_in;
   logic                  side_ff, side_in;
   logic [MAX_VERTICES-1:0] valid_ff, valid_in;
   logic [EB-1:0]         ea_ff, ea_in, eb_ff, eb_in;
   logic [SW-1:0]         ew_ff, ew_in;
   logic [VB-1:0]         x_ff, x_in, ca_ff, ca_in, cb_ff, cb_in;
   logic [EAW-1:0]        cc_ff, cc_in;
   logic [RKW-1:0]        rka_ff, rka_in;

   logic [VCW-1:0]        n_val;

   logic                  e_we;
   logic [EAW-1:0]        e_waddr, e_raddr;
   logic [EDW-1:0]        e_wdata, e_rdata;
   logic                  p_we;
   logic [VB-1:0]         p_waddr, p_raddr, p_wdata, p_rdata;
   logic                  r_we;
   logic [VB-1:0]         r_waddr, r_raddr;
   logic [RKW-1:0]        r_wdata, r_rdata;
   logic                  c_we;
   logic [VB-1:0]         c_waddr, c_raddr;
   logic [CHW-1:0]        c_wdata, c_rdata;
   logic                  t_we;
   logic [VB-1:0]         t_waddr, t_raddr;
   logic [EAW-1:0]        t_wdata, t_rdata;

   logic [EB-1:0]         rd_a, rd_b;
   logic [SW-1:0]         rd_w;
   logic [VB-1:0]         tgt;

   bsf_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata));
   bsf_ram #(.WIDTH(VB), .DEPTH(MAX_VERTICES)) u_parent (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(p_rdata));
   bsf_ram #(.WIDTH(RKW), .DEPTH(MAX_VERTICES)) u_rank (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .raddr(r_raddr), .rdata(r_rdata));
   bsf_ram #(.WIDTH(CHW), .DEPTH(MAX_VERTICES)) u_cheap (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata));
   bsf_ram #(.WIDTH(EAW), .DEPTH(MAX_VERTICES)) u_tree (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rdata));

   assign n_val = (vc_ff > VCB'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(vc_ff);
   assign {rd_a, rd_b, rd_w} = e_rdata;
   assign tgt   = side_ff ? cb_ff : ca_ff;
   assign busy  = (st_ff != S_IDLE);
   assign pready = 1'b1;
   assign prdata = paddr[2] ? '0 : bsf_pkg::CSR_DATA_BITS'(vc_ff);

   always_comb begin
      vc_in = vc_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         vc_in = pwdata[VCB-1:0];
      end
   end

   always_comb begin
      st_in = st_ff;    total_in = total_ff; e_in = e_ff;     ovf_in = ovf_ff;
      i_in = i_ff;      cnt_in = cnt_ff;     comp_in = comp_ff; k_in = k_ff;
      any_in = any_ff;  mode_in = mode_ff;   fsel_in = fsel_ff; side_in = side_ff;
      valid_in = valid_ff; ea_in = ea_ff;    eb_in = eb_ff;   ew_in = ew_ff;
      x_in = x_ff;      ca_in = ca_ff;       cb_in = cb_ff;   cc_in = cc_ff;
      rka_in = rka_ff;
      e_we = 1'b0; e_waddr = total_ff[EAW-1:0]; e_raddr = e_ff[EAW-1:0];
      e_wdata = {req_edge_from, req_edge_to, req_edge_weight[SW-1:0]};
      p_we = 1'b0; p_waddr = x_ff; p_wdata = p_rdata; p_raddr = x_ff;
      r_we = 1'b0; r_waddr = ca_ff; r_wdata = '0; r_raddr = ca_ff;
      c_we = 1'b0; c_waddr = tgt; c_wdata = {e_ff[EAW-1:0], ew_ff}; c_raddr = tgt;
      t_we = 1'b0; t_waddr = cnt_ff[VB-1:0]; t_wdata = cc_ff; t_raddr = k_ff[VB-1:0];
      rsp_valid = 1'b0; rsp_tree_from = '0; rsp_tree_to = '0; rsp_tree_weight = '0;
      rsp_has_edge = 1'b0; rsp_last_result = 1'b0; rsp_edges_dropped = ovf_ff;

      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               if (total_ff < ECW'(MAX_EDGES)) begin
                  e_we     = 1'b1;
                  total_in = total_ff + ECW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_edge) st_in = S_RUN;
            end
         end
         S_RUN: begin
            i_in = '0;
            if (n_val <= VCW'(1) || total_ff == '0) st_in = S_EMPTY;
            else st_in = S_INIT;
         end
         S_INIT: begin
            p_we = 1'b1; p_waddr = i_ff[VB-1:0]; p_wdata = i_ff[VB-1:0];
            r_we = 1'b1; r_waddr = i_ff[VB-1:0]; r_wdata = '0;
            if (i_ff == n_val - VCW'(1)) begin
               comp_in = n_val;
               cnt_in  = '0;
               st_in   = S_RND;
            end else begin
               i_in = i_ff + VCW'(1);
            end
         end
         S_RND: begin
            valid_in = '0; any_in = 1'b0; e_in = '0; mode_in = 1'b0;
            st_in = S_ERD;
         end
         S_ERD: st_in = S_EDAT;
         S_EDAT: begin
            ea_in = rd_a; eb_in = rd_b; ew_in = rd_w;
            if (VCB'(rd_a) >= VCB'(n_val) || VCB'(rd_b) >= VCB'(n_val)) begin
               st_in = S_NEXTE;
            end else begin
               x_in = rd_a[VB-1:0]; fsel_in = 1'b0; st_in = S_FRD;
            end
         end
         S_FRD: st_in = S_FP;
         S_FP: begin
            if (p_rdata == x_ff) begin
               if (!fsel_ff) begin
                  ca_in = x_ff; x_in = eb_ff[VB-1:0]; fsel_in = 1'b1; st_in = S_FRD;
               end else begin
                  cb_in = x_ff; st_in = S_FDONE;
               end
            end else begin
               p_raddr = p_rdata;
               st_in   = S_FGP;
            end
         end
         S_FGP: begin
            // path halving: point x at its grandparent and step there
            p_we = 1'b1; p_waddr = x_ff; p_wdata = p_rdata;
            x_in = p_rdata; st_in = S_FRD;
         end
         S_FDONE: begin
            if (ca_ff == cb_ff) begin
               if (mode_ff) begin
                  i_in = i_ff + VCW'(1); st_in = S_MSEL;
               end else begin
                  st_in = S_NEXTE;
               end
            end else if (mode_ff) begin
               r_raddr = ca_ff; st_in = S_RKA;
            end else begin
               side_in = 1'b0; st_in = S_CRD;
            end
         end
         S_CRD: st_in = S_CCK;
         S_CCK: begin
            // strict less-than keeps the earliest edge on a tie
            if (!valid_ff[tgt] || $signed(ew_ff) < $signed(c_rdata[SW-1:0])) begin
               c_we = 1'b1;
               valid_in[tgt] = 1'b1;
            end
            if (side_ff) begin
               st_in = S_NEXTE;
            end else begin
               side_in = 1'b1; st_in = S_CRD;
            end
         end
         S_NEXTE: begin
            if (e_ff + ECW'(1) == total_ff) begin
               i_in = '0; mode_in = 1'b1; st_in = S_MSEL;
            end else begin
               e_in = e_ff + ECW'(1); st_in = S_ERD;
            end
         end
         S_MSEL: begin
            if (i_ff == n_val) begin
               if (any_ff && comp_ff > VCW'(1) && cnt_ff + VCW'(1) < n_val) st_in = S_RND;
               else st_in = S_OUT;
            end else if (!valid_ff[i_ff[VB-1:0]]) begin
               i_in = i_ff + VCW'(1);
            end else begin
               any_in = 1'b1; c_raddr = i_ff[VB-1:0]; st_in = S_MCH;
            end
         end
         S_MCH: begin
            cc_in = c_rdata[SW +: EAW]; e_raddr = c_rdata[SW +: EAW]; st_in = S_MED;
         end
         S_MED: begin
            ea_in = rd_a; eb_in = rd_b; x_in = rd_a[VB-1:0]; fsel_in = 1'b0;
            st_in = S_FRD;
         end
         S_RKA: begin
            rka_in = r_rdata; r_raddr = cb_ff; st_in = S_RKB;
         end
         S_RKB: begin
            p_we = 1'b1;
            if (rka_ff < r_rdata) begin
               p_waddr = ca_ff; p_wdata = cb_ff;
            end else begin
               p_waddr = cb_ff; p_wdata = ca_ff;
               if (rka_ff == r_rdata) begin
                  r_we = 1'b1; r_waddr = ca_ff; r_wdata = rka_ff + RKW'(1);
               end
            end
            t_we = 1'b1;
            cnt_in  = cnt_ff + VCW'(1);
            comp_in = comp_ff - VCW'(1);
            i_in    = i_ff + VCW'(1);
            st_in   = S_MSEL;
         end
         S_OUT: begin
            k_in = '0;
            st_in = (cnt_ff == '0) ? S_EMPTY : S_ORD;
         end
         S_ORD: st_in = S_OCH;
         S_OCH: begin
            e_raddr = t_rdata; st_in = S_OED;
         end
         S_OED: begin
            rsp_valid = 1'b1; rsp_tree_from = rd_a; rsp_tree_to = rd_b;
            rsp_tree_weight = bsf_pkg::WEIGHT_PORT_BITS'($signed(rd_w));
            rsp_has_edge = 1'b1;
            rsp_last_result = (k_ff + VCW'(1) == cnt_ff);
            if (k_ff + VCW'(1) == cnt_ff) begin
               total_in = '0; ovf_in = 1'b0; st_in = S_IDLE;
            end else begin
               k_in = k_ff + VCW'(1); st_in = S_ORD;
            end
         end
         S_EMPTY: begin
            rsp_valid = 1'b1; rsp_last_result = 1'b1;
            total_in = '0; ovf_in = 1'b0; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         vc_ff    <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= '0;
      end else begin
         st_ff    <= st_in;
         vc_ff    <= vc_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
      e_ff <= e_in;     i_ff <= i_in;       cnt_ff <= cnt_in;   comp_ff <= comp_in;
      k_ff <= k_in;     any_ff <= any_in;   mode_ff <= mode_in; fsel_ff <= fsel_in;
      side_ff <= side_in; ea_ff <= ea_in;   eb_ff <= eb_in;     ew_ff <= ew_in;
      x_ff <= x_in;     ca_ff <= ca_in;     cb_ff <= cb_in;     cc_ff <= cc_in;
      rka_ff <= rka_in;
   end
endmodule

@@ verif/boruvka_spanning_forest_tb.sv @@
`timescale 1ns / 1ps
module boruvka_spanning_forest_tb;
   localparam int END_BITS         = bsf_pkg::END_BITS;
   localparam int WEIGHT_PORT_BITS = bsf_pkg::WEIGHT_PORT_BITS;
   localparam int CSR_ADDR_BITS    = bsf_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS    = bsf_pkg::CSR_DATA_BITS;
   localparam int VCOUNT_BITS      = bsf_pkg::VCOUNT_BITS;

   localparam int EDGE_CAP     = bsf_pkg::EDGE_MAX_DEF;
   localparam int VERT_CAP     = bsf_pkg::VERTEX_MAX_DEF;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_CYCS  = 40;
   localparam logic [CSR_ADDR_BITS-1:0] VCOUNT_ADDR = 3'd0;

   typedef struct {
      logic [END_BITS-1:0]                f;
      logic [END_BITS-1:0]                t;
      logic signed [WEIGHT_PORT_BITS-1:0] w;
      logic                               has;
      logic                               lastr;
      logic                               drop;
   } tree_rsp_type;

   class forest_scoreboard;
      logic [END_BITS-1:0]                ea[EDGE_CAP];
      logic [END_BITS-1:0]                eb[EDGE_CAP];
      logic signed [WEIGHT_PORT_BITS-1:0] ew[EDGE_CAP];
      int           edge_cnt;
      bit           overflow;
      int           vcount;
      int           par[VERT_CAP];
      int           rnk[VERT_CAP];
      tree_rsp_type pending[$];
      int           errors;

      function int find_root(int x);
         while (par[x] != x) begin
            par[x] = par[par[x]];
            x = par[x];
         end
         return x;
      endfunction

      function bit merge(int a, int b);
         int t;
         a = find_root(a);
         b = find_root(b);
         if (a == b) return 0;
         if (rnk[a] < rnk[b]) begin
            t = a; a = b; b = t;
         end
         par[b] = a;
         if (rnk[a] == rnk[b]) rnk[a]++;
         return 1;
      endfunction

      function void build_forest();
         int           n, comps, ca, cb, c;
         int           chosen[$];
         int           pick[VERT_CAP];
         bit           pick_ok[VERT_CAP];
         bit           any;
         tree_rsp_type r;
         n = (vcount > VERT_CAP) ? VERT_CAP : vcount;
         if (n > 1 && edge_cnt > 0) begin
            for (int i = 0; i < n; i++) begin
               par[i] = i;
               rnk[i] = 0;
            end
            comps = n;
            while (comps > 1 && chosen.size() < n - 1) begin
               for (int i = 0; i < n; i++) pick_ok[i] = 0;
               for (int e = 0; e < edge_cnt; e++) begin
                  if (ea[e] >= n || eb[e] >= n) continue;
                  ca = find_root(ea[e]);
                  cb = find_root(eb[e]);
                  if (ca == cb) continue;
                  if (!pick_ok[ca] || ew[e] < ew[pick[ca]]) begin
                     pick[ca] = e; pick_ok[ca] = 1;
                  end
                  if (!pick_ok[cb] || ew[e] < ew[pick[cb]]) begin
                     pick[cb] = e; pick_ok[cb] = 1;
                  end
               end
               any = 0;
               for (int i = 0; i < n; i++) begin
                  if (!pick_ok[i]) continue;
                  any = 1;
                  c = pick[i];
                  if (merge(ea[c], eb[c])) begin
                     chosen.push_back(c);
                     comps--;
                  end
               end
               if (!any) break;
            end
         end
         if (chosen.size() == 0) begin
            r = '{f: '0, t: '0, w: '0, has: 0, lastr: 1, drop: overflow};
            pending.push_back(r);
         end else begin
            foreach (chosen[k]) begin
               r.f = ea[chosen[k]];
               r.t = eb[chosen[k]];
               r.w = ew[chosen[k]];
               r.has = 1;
               r.lastr = (k == chosen.size() - 1);
               r.drop = overflow;
               pending.push_back(r);
            end
         end
      endfunction

      function void note_request(logic [END_BITS-1:0] f, logic [END_BITS-1:0] t,
                                 logic signed [WEIGHT_PORT_BITS-1:0] w, logic last);
         if (edge_cnt < EDGE_CAP) begin
            ea[edge_cnt] = f;
            eb[edge_cnt] = t;
            ew[edge_cnt] = w;
            edge_cnt++;
         end else begin
            overflow = 1;
         end
         if (!last) return;
         build_forest();
         edge_cnt = 0;
         overflow = 0;
      endfunction

      function void check_result(tree_rsp_type got);
         tree_rsp_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected tree edge from=%0d to=%0d w=%0d", $time,
                     got.f, got.t, got.w);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.f !== exp_r.f) begin
            $display("%0t: tree_from exp %0d got %0d", $time, exp_r.f, got.f); errors++;
         end
         if (got.t !== exp_r.t) begin
            $display("%0t: tree_to exp %0d got %0d", $time, exp_r.t, got.t); errors++;
         end
         if (got.w !== exp_r.w) begin
            $display("%0t: tree_weight exp %0d got %0d", $time, exp_r.w, got.w); errors++;
         end
         if (got.has !== exp_r.has) begin
            $display("%0t: has_edge exp %0b got %0b", $time, exp_r.has, got.has); errors++;
         end
         if (got.lastr !== exp_r.lastr) begin
            $display("%0t: last_result exp %0b got %0b", $time, exp_r.lastr, got.lastr);
            errors++;
         end
         if (got.drop !== exp_r.drop) begin
            $display("%0t: edges_dropped exp %0b got %0b", $time, exp_r.drop, got.drop);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [END_BITS-1:0] req_edge_from = '0;
   logic [END_BITS-1:0] req_edge_to = '0;
   logic signed [WEIGHT_PORT_BITS-1:0] req_edge_weight = '0;
   logic req_last_edge = 0;
   logic rsp_valid;
   logic [END_BITS-1:0] rsp_tree_from, rsp_tree_to;
   logic signed [WEIGHT_PORT_BITS-1:0] rsp_tree_weight;
   logic rsp_has_edge, rsp_last_result, rsp_edges_dropped;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   forest_scoreboard sb = new();
   int cycles = 0;

   boruvka_spanning_forest u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_edge_from(req_edge_from), .req_edge_to(req_edge_to),
      .req_edge_weight(req_edge_weight), .req_last_edge(req_last_edge),
      .rsp_valid(rsp_valid), .rsp_tree_from(rsp_tree_from), .rsp_tree_to(rsp_tree_to),
      .rsp_tree_weight(rsp_tree_weight), .rsp_has_edge(rsp_has_edge),
      .rsp_last_result(rsp_last_result), .rsp_edges_dropped(rsp_edges_dropped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("boruvka_spanning_forest: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{f: rsp_tree_from, t: rsp_tree_to, w: rsp_tree_weight,
                           has: rsp_has_edge, lastr: rsp_last_result,
                           drop: rsp_edges_dropped});
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic write_vcount(int v);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= VCOUNT_ADDR; pwdata <= CSR_DATA_BITS'(v);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.vcount = v & 7'h7f;
      // read it back
      @(posedge clock);
      psel <= 1; paddr <= VCOUNT_ADDR;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      if (prdata[VCOUNT_BITS-1:0] !== sb.vcount[VCOUNT_BITS-1:0]) begin
         $display("%0t: vertex_count read exp %0d got %0d", $time, sb.vcount, prdata);
         sb.errors++;
      end
      psel <= 0; penable <= 0;
   endtask

   // hold start only across the request; gaps drop it
   task automatic send_edge(int f, int t, logic signed [31:0] w, bit last, bit idle);
      int g;
      g = idle ? pick_gap() : 0;
      if (g > 0) begin
         start <= 0;
         repeat (g) @(posedge clock);
      end
      start <= 1;
      req_edge_from <= END_BITS'(f); req_edge_to <= END_BITS'(t);
      req_edge_weight <= w; req_last_edge <= last;
      do @(posedge clock); while (busy);
      sb.note_request(END_BITS'(f), END_BITS'(t), w, last);
      if (last) begin
         start <= 0;
         while (sb.pending.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCS) @(posedge clock);
      end
   endtask

   task automatic random_graph(int nv, int ne, bit idle);
      int f, t, r;
      logic signed [31:0] w;
      for (int i = 0; i < ne; i++) begin
         r = $urandom_range(0, 99);
         if (r < 85 && nv > 0) begin
            f = $urandom_range(0, (nv > 64 ? 64 : nv) - 1);
            t = $urandom_range(0, (nv > 64 ? 64 : nv) - 1);
         end else begin
            f = $urandom_range(0, 63);
            t = $urandom_range(0, 63);
         end
         r = $urandom_range(0, 99);
         if (r < 40) w = $urandom_range(0, 4);
         else if (r < 50) w = -$signed($urandom_range(0, 4));
         else w = $urandom;
         send_edge(f, t, w, i == ne - 1, idle);
      end
   endtask

   initial begin
      int sent, nv, ne;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty forest: no vertices, one vertex
      write_vcount(0);
      send_edge(0, 1, 5, 1, 0);
      write_vcount(1);
      send_edge(0, 0, 5, 1, 0);
      // two vertices: self loop only, then weight extremes with a tie
      write_vcount(2);
      send_edge(1, 1, -7, 1, 0);
      send_edge(0, 1, 32'sh7fffffff, 0, 0);
      send_edge(1, 0, 32'sh80000000, 0, 0);
      send_edge(0, 1, 32'sh80000000, 1, 0);
      // out-of-range endpoints and a disconnected graph
      write_vcount(5);
      send_edge(0, 63, -100, 0, 0);
      send_edge(5, 1, -100, 0, 0);
      send_edge(0, 1, 3, 0, 0);
      send_edge(3, 4, 3, 0, 0);
      send_edge(2, 2, -9, 1, 0);
      // full size, highest endpoints
      write_vcount(64);
      send_edge(63, 62, 1, 0, 0);
      send_edge(62, 0, 1, 0, 0);
      send_edge(63, 0, 1, 1, 0);
      // above the vertex limit behaves as the limit
      write_vcount(127);
      send_edge(63, 1, 42, 1, 0);

      // store overflow
      write_vcount(4);
      for (int i = 0; i < EDGE_CAP + 5; i++)
         send_edge($urandom_range(0, 5), $urandom_range(0, 5), $urandom,
                   i == EDGE_CAP + 4, 0);

      sent = 0;
      while (sent < 160) begin
         nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 16);
         ne = $urandom_range(1, 14);
         write_vcount(nv);
         random_graph(nv, ne, $urandom_range(0, 3) != 0);
         sent += ne;
      end
      write_vcount(64);
      random_graph(64, 40, 1);

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("boruvka_spanning_forest: match");
      else
         $display("boruvka_spanning_forest: mismatch");
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/bsf_pkg.sv
hw/rtl/bsf_ram.sv
hw/rtl/boruvka_spanning_forest.sv
verif/boruvka_spanning_forest_tb.sv
